FILE: design/smf_pkg.sv
// shared types, codes and result builders for the track event parser
`timescale 1ns / 1ps
`default_nettype none

package smf_pkg;

   localparam int TICK_BITS_DEF = 32;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

   localparam logic [1:0] KIND_CHANNEL = 2'd0;
   localparam logic [1:0] KIND_META = 2'd1;
   localparam logic [1:0] KIND_SYSEX = 2'd2;
   localparam logic [1:0] KIND_PAYLOAD = 2'd3;

   localparam logic [7:0] STATUS_META = 8'hFF;
   localparam logic [7:0] STATUS_SYSEX = 8'hF0;
   localparam logic [7:0] STATUS_SYSEX_ESC = 8'hF7;
   localparam logic [7:0] META_TEMPO = 8'h51;
   localparam logic [7:0] META_END_OF_TRACK = 8'h2F;
   localparam logic [3:0] CLASS_PROGRAM = 4'hC;
   localparam logic [3:0] CLASS_PRESSURE = 4'hD;
   localparam logic [31:0] TEMPO_LENGTH = 32'd3;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [31:0] abs_tick;
      logic [7:0]  status_value;
      logic [7:0]  first_data;
      logic [7:0]  second_data;
      logic [7:0]  meta_kind;
      logic [31:0] payload_count;
      logic [7:0]  payload_value;
      logic [23:0] tempo_us;
      logic        tempo_valid;
      logic        chunk_done;
      logic        last;
   } result_type;

   typedef struct packed {
      logic [FIFO_CNT_BITS-1:0] count;
      logic                     full;
   } fifo_status_type;

   function automatic logic one_data_byte(input logic [7:0] status);
      return (status[7:4] == CLASS_PROGRAM) || (status[7:4] == CLASS_PRESSURE);
   endfunction

   function automatic result_type make_channel(input logic [7:0] status,
                                               input logic [7:0] d1,
                                               input logic [7:0] d2,
                                               input logic [31:0] tick,
                                               input logic done);
      result_type r;
      r = '0;
      r.result_kind = KIND_CHANNEL;
      r.abs_tick = tick;
      r.status_value = status;
      r.first_data = d1;
      r.second_data = d2;
      r.chunk_done = done;
      return r;
   endfunction

   function automatic result_type make_block(input logic [7:0] status,
                                             input logic [7:0] meta_kind,
                                             input logic [31:0] total,
                                             input logic [23:0] tempo,
                                             input logic [31:0] tick,
                                             input logic body_used);
      result_type r;
      logic       is_meta;
      logic       tv;
      r = '0;
      is_meta = (status == STATUS_META);
      tv = is_meta && (meta_kind == META_TEMPO) && (total == TEMPO_LENGTH);
      r.result_kind = is_meta ? KIND_META : KIND_SYSEX;
      r.abs_tick = tick;
      r.status_value = status;
      r.meta_kind = is_meta ? meta_kind : 8'h00;
      r.payload_count = total;
      r.tempo_us = tv ? tempo : 24'h000000;
      r.tempo_valid = tv;
      r.chunk_done = body_used || (is_meta && (meta_kind == META_END_OF_TRACK));
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: design/smf_track_event_parser.sv
// top level of the midi track chunk event parser
//
//   channel | direction | words                     | handshake
//   req     | in        | one track byte            | req_valid / req_ready
//   rsp     | out       | one event or payload byte | rsp_valid / rsp_ready
//
// one byte is taken per cycle while req_ready is high; each byte is decoded in the cycle it is taken
// and its results (none, one or two) land in a four-entry result queue
// a byte that ends a payload gives two results; the queue drains at one per cycle while rsp_ready is high
// req_ready is high while the queue has room for two results
// synchronous reset returns the parser to awaiting a chunk header and empties the queue
`timescale 1ns / 1ps
`default_nettype none

module smf_track_event_parser #(
   parameter int TICK_BITS = smf_pkg::TICK_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_track_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_result_kind,
   output logic [31:0]      rsp_abs_tick,
   output logic [7:0]       rsp_status_value,
   output logic [7:0]       rsp_first_data,
   output logic [7:0]       rsp_second_data,
   output logic [7:0]       rsp_meta_kind,
   output logic [31:0]      rsp_payload_count,
   output logic [7:0]       rsp_payload_value,
   output logic [23:0]      rsp_tempo_us,
   output logic             rsp_tempo_valid,
   output logic             rsp_chunk_done,
   output logic             rsp_last
);

   smf_pkg::result_type      res_first;
   smf_pkg::result_type      res_second;
   smf_pkg::result_type      head;
   smf_pkg::fifo_status_type fifo_status;
   logic [1:0]               res_count;
   logic                     word_take;

   assign req_ready = (fifo_status.count
                       <= smf_pkg::FIFO_CNT_BITS'(smf_pkg::FIFO_DEPTH - 2));
   assign word_take = req_valid && req_ready;

   smf_parse_core #(
      .TICK_BITS(TICK_BITS)
   ) u_core (
      .clock(clock),
      .reset(reset),
      .word_take(word_take),
      .word_byte(req_track_byte),
      .res_first(res_first),
      .res_second(res_second),
      .res_count(res_count)
   );

   smf_result_fifo u_fifo (
      .clock(clock),
      .reset(reset),
      .push_first(res_first),
      .push_second(res_second),
      .push_count(res_count),
      .pop_valid(rsp_valid),
      .pop_ready(rsp_ready),
      .pop_data(head),
      .status(fifo_status)
   );

   assign rsp_result_kind = head.result_kind;
   assign rsp_abs_tick = head.abs_tick;
   assign rsp_status_value = head.status_value;
   assign rsp_first_data = head.first_data;
   assign rsp_second_data = head.second_data;
   assign rsp_meta_kind = head.meta_kind;
   assign rsp_payload_count = head.payload_count;
   assign rsp_payload_value = head.payload_value;
   assign rsp_tempo_us = head.tempo_us;
   assign rsp_tempo_valid = head.tempo_valid;
   assign rsp_chunk_done = head.chunk_done;
   assign rsp_last = head.last;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(fifo_status.full && (res_count != 2'd0)))
      else $error("result queue written while full");

   a_results_only_on_take: assert property (@(posedge clock) disable iff (reset)
      !word_take |-> (res_count == 2'd0))
      else $error("results produced without a byte taken");

   a_pair_shows_next: assert property (@(posedge clock) disable iff (reset)
      (res_count == 2'd2) |=> (rsp_valid && (fifo_status.count >= 2)))
      else $error("two results taken but queue not holding them");

   a_payload_not_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_result_kind == smf_pkg::KIND_PAYLOAD))
      |-> (!rsp_chunk_done && !rsp_tempo_valid))
      else $error("payload byte flagged as chunk end or tempo");

endmodule

`default_nettype wire

FILE: design/smf_parse_core.sv
// parser state and per-word result decode
`timescale 1ns / 1ps
`default_nettype none

module smf_parse_core #(
   parameter int TICK_BITS = smf_pkg::TICK_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              word_take,
   input  wire logic [7:0]        word_byte,
   output smf_pkg::result_type    res_first,
   output smf_pkg::result_type    res_second,
   output logic [1:0]             res_count
);

   localparam logic [3:0] PH_HEADER = 4'd0;
   localparam logic [3:0] PH_DELTA = 4'd1;
   localparam logic [3:0] PH_STATUS = 4'd2;
   localparam logic [3:0] PH_DATA1 = 4'd3;
   localparam logic [3:0] PH_DATA2 = 4'd4;
   localparam logic [3:0] PH_META_TYPE = 4'd5;
   localparam logic [3:0] PH_META_LEN = 4'd6;
   localparam logic [3:0] PH_SYSEX_LEN = 4'd7;
   localparam logic [3:0] PH_PAYLOAD = 4'd8;

   logic [3:0]           phase_ff, phase_in;
   logic [2:0]           header_count_ff, header_count_in;
   logic [31:0]          body_length_ff, body_length_in;
   logic [31:0]          body_consumed_ff, body_consumed_in;
   logic [31:0]          vlq_accum_ff, vlq_accum_in;
   logic [TICK_BITS-1:0] tick_total_ff, tick_total_in;
   logic [3:0]           running_kind_ff, running_kind_in;
   logic [3:0]           running_chan_ff, running_chan_in;
   logic [7:0]           event_status_ff, event_status_in;
   logic [7:0]           held_data_ff, held_data_in;
   logic [7:0]           held_meta_kind_ff, held_meta_kind_in;
   logic [31:0]          payload_left_ff, payload_left_in;
   logic [31:0]          payload_total_ff, payload_total_in;
   logic [23:0]          tempo_accum_ff, tempo_accum_in;

   logic [TICK_BITS+31:0] tick_wide;
   logic [31:0]           tick_now;
   logic [31:0]           vlq_shift;
   logic                  vlq_end;
   logic [7:0]            running_status;
   logic                  body_used;
   logic [31:0]           consumed_step;
   logic [23:0]           tempo_shift;
   logic                  event_end;
   logic                  event_done;

   assign tick_wide = {32'h0000_0000, tick_total_ff};
   assign tick_now = tick_wide[31:0];
   assign vlq_shift = {vlq_accum_ff[24:0], word_byte[6:0]};
   assign vlq_end = !word_byte[7];
   assign running_status = {running_kind_ff, running_chan_ff};
   assign consumed_step = (body_consumed_ff == 32'hFFFF_FFFF) ? body_consumed_ff
                                                               : body_consumed_ff + 32'd1;
   assign body_used = (consumed_step >= body_length_ff);
   assign tempo_shift = {tempo_accum_ff[15:0], word_byte};

   always_comb begin
      phase_in = phase_ff;
      header_count_in = header_count_ff;
      body_length_in = body_length_ff;
      body_consumed_in = body_consumed_ff;
      vlq_accum_in = vlq_accum_ff;
      tick_total_in = tick_total_ff;
      running_kind_in = running_kind_ff;
      running_chan_in = running_chan_ff;
      event_status_in = event_status_ff;
      held_data_in = held_data_ff;
      held_meta_kind_in = held_meta_kind_ff;
      payload_left_in = payload_left_ff;
      payload_total_in = payload_total_ff;
      tempo_accum_in = tempo_accum_ff;
      res_first = '0;
      res_second = '0;
      res_count = 2'd0;
      event_end = 1'b0;
      event_done = 1'b0;

      if (word_take) begin
         if (phase_ff != PH_HEADER) begin
            body_consumed_in = consumed_step;
         end
         unique case (phase_ff)
            PH_HEADER: begin
               if (header_count_ff[2]) begin
                  body_length_in = {body_length_ff[23:0], word_byte};
               end
               header_count_in = header_count_ff + 3'd1;
               if (header_count_ff == 3'd7) begin
                  if (body_length_in != 32'h0000_0000) begin
                     phase_in = PH_DELTA;
                     vlq_accum_in = '0;
                  end
               end
            end
            PH_DELTA: begin
               vlq_accum_in = vlq_shift;
               if (vlq_end) begin
                  tick_total_in = tick_total_ff + TICK_BITS'(vlq_shift);
                  phase_in = PH_STATUS;
               end
            end
            PH_STATUS: begin
               if (word_byte == smf_pkg::STATUS_META) begin
                  event_status_in = smf_pkg::STATUS_META;
                  phase_in = PH_META_TYPE;
               end else if ((word_byte == smf_pkg::STATUS_SYSEX)
                            || (word_byte == smf_pkg::STATUS_SYSEX_ESC)) begin
                  event_status_in = word_byte;
                  vlq_accum_in = '0;
                  phase_in = PH_SYSEX_LEN;
               end else if (word_byte[7]) begin
                  running_kind_in = word_byte[7:4];
                  running_chan_in = word_byte[3:0];
                  event_status_in = word_byte;
                  phase_in = PH_DATA1;
               end else begin
                  event_status_in = running_status;
                  if (smf_pkg::one_data_byte(running_status)) begin
                     res_first = smf_pkg::make_channel(running_status, word_byte, 8'h00,
                                                       tick_now, body_used);
                     res_first.last = 1'b1;
                     res_count = 2'd1;
                     event_end = 1'b1;
                     event_done = body_used;
                  end else begin
                     held_data_in = word_byte;
                     phase_in = PH_DATA2;
                  end
               end
            end
            PH_DATA1: begin
               if (smf_pkg::one_data_byte(event_status_ff)) begin
                  res_first = smf_pkg::make_channel(event_status_ff, word_byte, 8'h00,
                                                    tick_now, body_used);
                  res_first.last = 1'b1;
                  res_count = 2'd1;
                  event_end = 1'b1;
                  event_done = body_used;
               end else begin
                  held_data_in = word_byte;
                  phase_in = PH_DATA2;
               end
            end
            PH_DATA2: begin
               res_first = smf_pkg::make_channel(event_status_ff, held_data_ff, word_byte,
                                                 tick_now, body_used);
               res_first.last = 1'b1;
               res_count = 2'd1;
               event_end = 1'b1;
               event_done = body_used;
            end
            PH_META_TYPE: begin
               held_meta_kind_in = word_byte;
               vlq_accum_in = '0;
               phase_in = PH_META_LEN;
            end
            PH_META_LEN, PH_SYSEX_LEN: begin
               vlq_accum_in = vlq_shift;
               if (vlq_end) begin
                  payload_left_in = vlq_shift;
                  payload_total_in = vlq_shift;
                  tempo_accum_in = '0;
                  if (vlq_shift == 32'h0000_0000) begin
                     res_first = smf_pkg::make_block(event_status_ff, held_meta_kind_ff,
                                                     32'h0000_0000, 24'h000000,
                                                     tick_now, body_used);
                     res_first.last = 1'b1;
                     res_count = 2'd1;
                     event_end = 1'b1;
                     event_done = res_first.chunk_done;
                  end else begin
                     phase_in = PH_PAYLOAD;
                  end
               end
            end
            PH_PAYLOAD: begin
               res_first = '0;
               res_first.result_kind = smf_pkg::KIND_PAYLOAD;
               res_first.abs_tick = tick_now;
               res_first.status_value = event_status_ff;
               res_first.meta_kind = (event_status_ff == smf_pkg::STATUS_META)
                                     ? held_meta_kind_ff : 8'h00;
               res_first.payload_count = payload_total_ff;
               res_first.payload_value = word_byte;
               res_first.last = 1'b1;
               res_count = 2'd1;
               tempo_accum_in = tempo_shift;
               payload_left_in = payload_left_ff - 32'd1;
               if (payload_left_ff == 32'd1) begin
                  res_first.last = 1'b0;
                  res_second = smf_pkg::make_block(event_status_ff, held_meta_kind_ff,
                                                   payload_total_ff, tempo_shift,
                                                   tick_now, body_used);
                  res_second.last = 1'b1;
                  res_count = 2'd2;
                  event_end = 1'b1;
                  event_done = res_second.chunk_done;
               end
            end
            default: begin
               event_end = 1'b1;
               event_done = 1'b1;
            end
         endcase

         if (event_end) begin
            if (event_done) begin
               phase_in = PH_HEADER;
               header_count_in = '0;
               body_length_in = '0;
               body_consumed_in = '0;
               vlq_accum_in = '0;
               tick_total_in = '0;
               running_kind_in = '0;
               running_chan_in = '0;
               event_status_in = '0;
               held_data_in = '0;
               held_meta_kind_in = '0;
               payload_left_in = '0;
               payload_total_in = '0;
               tempo_accum_in = '0;
            end else begin
               phase_in = PH_DELTA;
               vlq_accum_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         header_count_ff <= '0;
         body_length_ff <= '0;
         body_consumed_ff <= '0;
         vlq_accum_ff <= '0;
         tick_total_ff <= '0;
         running_kind_ff <= '0;
         running_chan_ff <= '0;
         event_status_ff <= '0;
         held_data_ff <= '0;
         held_meta_kind_ff <= '0;
         payload_left_ff <= '0;
         payload_total_ff <= '0;
         tempo_accum_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         header_count_ff <= header_count_in;
         body_length_ff <= body_length_in;
         body_consumed_ff <= body_consumed_in;
         vlq_accum_ff <= vlq_accum_in;
         tick_total_ff <= tick_total_in;
         running_kind_ff <= running_kind_in;
         running_chan_ff <= running_chan_in;
         event_status_ff <= event_status_in;
         held_data_ff <= held_data_in;
         held_meta_kind_ff <= held_meta_kind_in;
         payload_left_ff <= payload_left_in;
         payload_total_ff <= payload_total_in;
         tempo_accum_ff <= tempo_accum_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/smf_result_fifo.sv
// small result queue taking up to two results per cycle
`timescale 1ns / 1ps
`default_nettype none

module smf_result_fifo (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire smf_pkg::result_type    push_first,
   input  wire smf_pkg::result_type    push_second,
   input  wire logic [1:0]             push_count,
   output logic                        pop_valid,
   input  wire logic                   pop_ready,
   output smf_pkg::result_type         pop_data,
   output smf_pkg::fifo_status_type    status
);

   smf_pkg::result_type entry_ff [smf_pkg::FIFO_DEPTH];

   logic [smf_pkg::FIFO_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [smf_pkg::FIFO_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [smf_pkg::FIFO_CNT_BITS-1:0] count_ff, count_in;
   logic [smf_pkg::FIFO_PTR_BITS-1:0] wr_ptr_next;
   logic                              pop;

   assign pop_valid = (count_ff != '0);
   assign pop = pop_valid && pop_ready;
   assign pop_data = entry_ff[rd_ptr_ff];
   assign wr_ptr_next = wr_ptr_ff + smf_pkg::FIFO_PTR_BITS'(1);

   assign wr_ptr_in = wr_ptr_ff + smf_pkg::FIFO_PTR_BITS'(push_count);
   assign rd_ptr_in = rd_ptr_ff + smf_pkg::FIFO_PTR_BITS'(pop);
   assign count_in = count_ff + smf_pkg::FIFO_CNT_BITS'(push_count)
                     - smf_pkg::FIFO_CNT_BITS'(pop);

   assign status.count = count_ff;
   assign status.full = (count_ff == smf_pkg::FIFO_CNT_BITS'(smf_pkg::FIFO_DEPTH));

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push_first;
      end
      if (push_count == 2'd2) begin
         entry_ff[wr_ptr_next] <= push_second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

FILE: tb/smf_result_checker.sv
// checker for the midi track event parser: predicts each result word and compares
`timescale 1ns / 1ps

module smf_result_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire logic [7:0]  req_track_byte,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic [1:0]  rsp_result_kind,
   input  wire logic [31:0] rsp_abs_tick,
   input  wire logic [7:0]  rsp_status_value,
   input  wire logic [7:0]  rsp_first_data,
   input  wire logic [7:0]  rsp_second_data,
   input  wire logic [7:0]  rsp_meta_kind,
   input  wire logic [31:0] rsp_payload_count,
   input  wire logic [7:0]  rsp_payload_value,
   input  wire logic [23:0] rsp_tempo_us,
   input  wire logic        rsp_tempo_valid,
   input  wire logic        rsp_chunk_done,
   input  wire logic        rsp_last,
   output int               failures,
   output int               pending
);

   typedef enum logic [3:0] {
      AWAIT_HEADER, READ_DELTA, READ_STATUS, READ_DATA1, READ_DATA2,
      READ_META_TYPE, READ_META_LEN, READ_SYSEX_LEN, READ_PAYLOAD
   } parse_step_type;

   parse_step_type step;
   logic [3:0]  header_count;
   logic [31:0] body_length;
   logic [31:0] bytes_used;
   logic [31:0] vlq_value;
   logic [31:0] tick_count;
   logic [7:0]  running_status;
   logic [7:0]  cur_status;
   logic [7:0]  held_byte;
   logic [7:0]  meta_type;
   logic [31:0] bytes_left;
   logic [31:0] block_length;
   logic [23:0] tempo_value;

   smf_pkg::result_type expected_words[$];
   int         produced;
   int         mismatches = 0;
   int         outstanding = 0;

   assign failures = mismatches;
   assign pending = outstanding;

   task automatic report(input string what);
      mismatches++;
      $display("error at %0t: %s", $time, what);
   endtask

   task automatic restart_parser();
      step = AWAIT_HEADER;
      header_count = '0;
      body_length = '0;
      bytes_used = '0;
      vlq_value = '0;
      tick_count = '0;
      running_status = '0;
      cur_status = '0;
      held_byte = '0;
      meta_type = '0;
      bytes_left = '0;
      block_length = '0;
      tempo_value = '0;
   endtask

   function automatic bit one_byte_class(input logic [7:0] s);
      return (s[7:4] == smf_pkg::CLASS_PROGRAM) || (s[7:4] == smf_pkg::CLASS_PRESSURE);
   endfunction

   task automatic add_expected(input smf_pkg::result_type word);
      expected_words.insert(expected_words.size(), word);
      produced++;
   endtask

   task automatic end_event(input bit done);
      if (done) begin
         restart_parser();
      end else begin
         step = READ_DELTA;
         vlq_value = '0;
      end
   endtask

   task automatic finish_channel(input logic [7:0] d1, input logic [7:0] d2);
      smf_pkg::result_type word;
      bit         done;
      done = bytes_used >= body_length;
      word = '0;
      word.result_kind = smf_pkg::KIND_CHANNEL;
      word.abs_tick = tick_count;
      word.status_value = cur_status;
      word.first_data = d1;
      word.second_data = d2;
      word.chunk_done = done;
      add_expected(word);
      end_event(done);
   endtask

   task automatic finish_block();
      smf_pkg::result_type word;
      bit         done;
      bit         tempo_ok;
      word = '0;
      word.abs_tick = tick_count;
      word.status_value = cur_status;
      word.payload_count = block_length;
      if (cur_status == smf_pkg::STATUS_META) begin
         tempo_ok = (meta_type == smf_pkg::META_TEMPO)
                    && (block_length == smf_pkg::TEMPO_LENGTH);
         done = (meta_type == smf_pkg::META_END_OF_TRACK) || (bytes_used >= body_length);
         word.result_kind = smf_pkg::KIND_META;
         word.meta_kind = meta_type;
         word.tempo_us = tempo_ok ? tempo_value : '0;
         word.tempo_valid = tempo_ok;
      end else begin
         done = bytes_used >= body_length;
         word.result_kind = smf_pkg::KIND_SYSEX;
      end
      word.chunk_done = done;
      add_expected(word);
      end_event(done);
   endtask

   task automatic decode_byte(input logic [7:0] b);
      smf_pkg::result_type word;
      produced = 0;
      if (step == AWAIT_HEADER) begin
         if (header_count >= 4) body_length = {body_length[23:0], b};
         header_count = header_count + 4'd1;
         if (header_count == 4'd8) begin
            header_count = '0;
            if (body_length == 0) begin
               restart_parser();
            end else begin
               step = READ_DELTA;
               vlq_value = '0;
            end
         end
      end else begin
         if (bytes_used != 32'hFFFF_FFFF) bytes_used = bytes_used + 32'd1;
         case (step)
            READ_DELTA: begin
               vlq_value = {vlq_value[24:0], b[6:0]};
               if (!b[7]) begin
                  tick_count = tick_count + vlq_value;
                  step = READ_STATUS;
               end
            end
            READ_STATUS: begin
               if (b == smf_pkg::STATUS_META) begin
                  cur_status = b;
                  step = READ_META_TYPE;
               end else if (b == smf_pkg::STATUS_SYSEX || b == smf_pkg::STATUS_SYSEX_ESC) begin
                  cur_status = b;
                  vlq_value = '0;
                  step = READ_SYSEX_LEN;
               end else if (b[7]) begin
                  running_status = b;
                  cur_status = b;
                  step = READ_DATA1;
               end else begin
                  cur_status = running_status;
                  if (one_byte_class(cur_status)) begin
                     finish_channel(b, 8'h00);
                  end else begin
                     held_byte = b;
                     step = READ_DATA2;
                  end
               end
            end
            READ_DATA1: begin
               if (one_byte_class(cur_status)) begin
                  finish_channel(b, 8'h00);
               end else begin
                  held_byte = b;
                  step = READ_DATA2;
               end
            end
            READ_DATA2: begin
               finish_channel(held_byte, b);
            end
            READ_META_TYPE: begin
               meta_type = b;
               vlq_value = '0;
               step = READ_META_LEN;
            end
            READ_META_LEN, READ_SYSEX_LEN: begin
               vlq_value = {vlq_value[24:0], b[6:0]};
               if (!b[7]) begin
                  bytes_left = vlq_value;
                  block_length = vlq_value;
                  tempo_value = '0;
                  if (vlq_value == 0) finish_block();
                  else step = READ_PAYLOAD;
               end
            end
            READ_PAYLOAD: begin
               word = '0;
               word.result_kind = smf_pkg::KIND_PAYLOAD;
               word.abs_tick = tick_count;
               word.status_value = cur_status;
               word.meta_kind = (cur_status == smf_pkg::STATUS_META) ? meta_type : 8'h00;
               word.payload_count = block_length;
               word.payload_value = b;
               add_expected(word);
               tempo_value = {tempo_value[15:0], b};
               bytes_left = bytes_left - 32'd1;
               if (bytes_left == 0) finish_block();
            end
            default: begin
               restart_parser();
            end
         endcase
      end
      // the final word caused by this byte carries the last flag
      if (produced > 0) begin
         word = expected_words[expected_words.size() - 1];
         word.last = 1'b1;
         expected_words[expected_words.size() - 1] = word;
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) report($sformatf("%s is %0h, expected %0h", name, got, want));
   endtask

   task automatic compare_word();
      smf_pkg::result_type want;
      if (expected_words.size() == 0) begin
         report($sformatf("word of kind %0d with nothing expected", rsp_result_kind));
      end else begin
         want = expected_words.pop_front();
         check_field("result_kind", 32'(rsp_result_kind), 32'(want.result_kind));
         check_field("abs_tick", rsp_abs_tick, want.abs_tick);
         check_field("status_value", 32'(rsp_status_value), 32'(want.status_value));
         check_field("first_data", 32'(rsp_first_data), 32'(want.first_data));
         check_field("second_data", 32'(rsp_second_data), 32'(want.second_data));
         check_field("meta_kind", 32'(rsp_meta_kind), 32'(want.meta_kind));
         check_field("payload_count", rsp_payload_count, want.payload_count);
         check_field("payload_value", 32'(rsp_payload_value), 32'(want.payload_value));
         check_field("tempo_us", 32'(rsp_tempo_us), 32'(want.tempo_us));
         check_field("tempo_valid", 32'(rsp_tempo_valid), 32'(want.tempo_valid));
         check_field("chunk_done", 32'(rsp_chunk_done), 32'(want.chunk_done));
         check_field("last", 32'(rsp_last), 32'(want.last));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         restart_parser();
         expected_words.delete();
      end else begin
         if (req_valid && req_ready) decode_byte(req_track_byte);
         if (rsp_valid && rsp_ready) compare_word();
      end
      outstanding = expected_words.size();
   end

endmodule

FILE: tb/tb.sv
// testbench top for the midi track event parser: stimulus, flow control and verdict
`timescale 1ns / 1ps

module tb;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_track_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_result_kind;
   logic [31:0] rsp_abs_tick;
   logic [7:0]  rsp_status_value;
   logic [7:0]  rsp_first_data;
   logic [7:0]  rsp_second_data;
   logic [7:0]  rsp_meta_kind;
   logic [31:0] rsp_payload_count;
   logic [7:0]  rsp_payload_value;
   logic [23:0] rsp_tempo_us;
   logic        rsp_tempo_valid;
   logic        rsp_chunk_done;
   logic        rsp_last;
   int          failures;
   int          pending;

   logic [7:0]  track_stream[$];
   logic [7:0]  chunk_body[$];
   logic [7:0]  gen_running = 8'h00;

   always #6 clock = ~clock;

   smf_track_event_parser dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_track_byte    (req_track_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_abs_tick      (rsp_abs_tick),
      .rsp_status_value  (rsp_status_value),
      .rsp_first_data    (rsp_first_data),
      .rsp_second_data   (rsp_second_data),
      .rsp_meta_kind     (rsp_meta_kind),
      .rsp_payload_count (rsp_payload_count),
      .rsp_payload_value (rsp_payload_value),
      .rsp_tempo_us      (rsp_tempo_us),
      .rsp_tempo_valid   (rsp_tempo_valid),
      .rsp_chunk_done    (rsp_chunk_done),
      .rsp_last          (rsp_last)
   );

   smf_result_checker result_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_track_byte    (req_track_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_abs_tick      (rsp_abs_tick),
      .rsp_status_value  (rsp_status_value),
      .rsp_first_data    (rsp_first_data),
      .rsp_second_data   (rsp_second_data),
      .rsp_meta_kind     (rsp_meta_kind),
      .rsp_payload_count (rsp_payload_count),
      .rsp_payload_value (rsp_payload_value),
      .rsp_tempo_us      (rsp_tempo_us),
      .rsp_tempo_valid   (rsp_tempo_valid),
      .rsp_chunk_done    (rsp_chunk_done),
      .rsp_last          (rsp_last),
      .failures          (failures),
      .pending           (pending)
   );

   task automatic body_add(input logic [7:0] b);
      chunk_body.insert(chunk_body.size(), b);
   endtask

   task automatic stream_add(input logic [7:0] b);
      track_stream.insert(track_stream.size(), b);
   endtask

   function automatic bit short_message(input logic [7:0] s);
      return (s[7:4] == smf_pkg::CLASS_PROGRAM) || (s[7:4] == smf_pkg::CLASS_PRESSURE);
   endfunction

   // variable-length number, optionally padded with leading continuation bytes;
   // bits that fall off the top of the 32-bit accumulator are random
   task automatic add_vlq(input logic [31:0] value, input int pad);
      int         width;
      int         i;
      logic [7:0] b;
      logic [2:0] spill;
      width = 1;
      while (width < 5 && (value >> (7 * width)) != 0) width++;
      width = width + pad;
      for (i = width - 1; i >= 0; i--) begin
         spill = 3'($urandom_range(0, 7));
         if (i >= 5) b = 8'($urandom_range(0, 127));
         else if (i == 4) b = {1'b0, spill, value[31:28]};
         else b = {1'b0, value[7 * i +: 7]};
         b[7] = (i != 0);
         body_add(b);
      end
   endtask

   task automatic add_seq(input logic [255:0] seq, input int count);
      int i;
      for (i = count - 1; i >= 0; i--) body_add(seq[8 * i +: 8]);
   endtask

   task automatic add_payload(input int count);
      int i;
      for (i = 0; i < count; i++) body_add(8'($urandom_range(0, 255)));
   endtask

   task automatic close_chunk(input logic [31:0] body_len);
      int i;
      for (i = 0; i < 4; i++) stream_add(8'($urandom_range(0, 255)));
      for (i = 3; i >= 0; i--) stream_add(body_len[8 * i +: 8]);
      foreach (chunk_body[j]) stream_add(chunk_body[j]);
      chunk_body.delete();
      gen_running = 8'h00;
   endtask

   task automatic add_event(input bit end_track);
      int         pick;
      int         count;
      logic [7:0] status;
      logic [7:0] kind;
      pick = $urandom_range(0, 15);
      if (pick < 11) add_vlq($urandom_range(0, 127), 0);
      else if (pick < 13) add_vlq($urandom_range(0, 32'h1F_FFFF), 0);
      else if (pick < 15) add_vlq($urandom, 0);
      else add_vlq($urandom, $urandom_range(1, 3));
      pick = end_track ? -1 : $urandom_range(0, 19);
      if (pick < 0) begin
         count = $urandom_range(0, 2);
         add_seq(256'({smf_pkg::STATUS_META, smf_pkg::META_END_OF_TRACK}), 2);
         add_vlq(count, 0);
         add_payload(count);
      end else if (pick < 9) begin
         status = 8'($urandom_range(8'h80, 8'hEF));
         gen_running = status;
         body_add(status);
         add_payload(short_message(status) ? 1 : 2);
      end else if (pick < 13) begin
         // running status
         body_add(8'($urandom_range(0, 127)));
         if (!short_message(gen_running)) add_payload(1);
      end else if (pick < 16) begin
         kind = 8'($urandom_range(0, 255));
         if ($urandom_range(0, 2) == 0 || kind == smf_pkg::META_END_OF_TRACK) begin
            kind = smf_pkg::META_TEMPO;
         end
         count = (kind == smf_pkg::META_TEMPO && $urandom_range(0, 3) != 0)
                 ? 3 : $urandom_range(0, 5);
         add_seq(256'({smf_pkg::STATUS_META, kind}), 2);
         add_vlq(count, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
         add_payload(count);
      end else if (pick < 18) begin
         count = $urandom_range(0, 6);
         body_add(($urandom_range(0, 1) == 0) ? smf_pkg::STATUS_SYSEX
                                               : smf_pkg::STATUS_SYSEX_ESC);
         add_vlq(count, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
         add_payload(count);
      end else begin
         // other system statuses act as two-byte channel statuses
         status = 8'($urandom_range(8'hF1, 8'hFE));
         if (status == smf_pkg::STATUS_SYSEX_ESC) status = 8'hF8;
         gen_running = status;
         body_add(status);
         add_payload(2);
      end
   endtask

   initial begin
      #10_000_000;
      $display("Verification failed");
      $finish;
   end

   initial begin : drain_results
      int gap;
      int taken;
      bit no_idle;
      rsp_ready <= 1'b0;
      taken = 0;
      no_idle = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if ($urandom_range(0, 31) == 0) no_idle = !no_idle;
         gap = no_idle ? 0 : $urandom_range(0, 8);
         // one long hold-off so the result queue fills and input stalls
         if (taken == 150) gap = 400;
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         taken++;
      end
   end

   initial begin : feed_track
      int          gap;
      int          n_events;
      int          mode;
      int          last_start;
      int          i;
      bit          no_idle;
      logic [31:0] body_len;

      reset <= 1'b1;
      req_valid <= 1'b0;
      req_track_byte <= 8'h00;
      no_idle = 1'b0;

      // running status before any status, then one-byte classes, data with top bit set
      add_seq(256'({8'h00, 8'h12, 8'h34, 8'h00, 8'hC5, 8'h7F, 8'h00, 8'h40,
                    8'h00, 8'hD3, 8'h80, 8'h00, 8'hEF, 8'hFF, 8'hFF}), 15);
      // system status becomes running status
      add_seq(256'({8'h00, 8'hF3, 8'h01, 8'hFF, 8'h00, 8'h05, 8'h06}), 7);
      // largest delta, then a padded delta that wraps the tick back to zero
      add_vlq(32'hFFFF_FFFF, 0);
      add_seq(256'({8'h90, 8'h3C, 8'h40}), 3);
      add_vlq(32'd1, 5);
      add_seq(256'({smf_pkg::STATUS_META, smf_pkg::META_TEMPO, 8'h03, 8'h07, 8'hA1,
                    8'h20}), 6);
      // tempo with an over-long length field
      add_seq(256'({8'h00, smf_pkg::STATUS_META, smf_pkg::META_TEMPO}), 3);
      add_vlq(32'd3, 5);
      add_seq(256'({8'hFF, 8'h00, 8'h80}), 3);
      // tempo of the wrong length, empty meta and sysex, escaped sysex
      add_seq(256'({8'h00, smf_pkg::STATUS_META, smf_pkg::META_TEMPO, 8'h02, 8'hAA, 8'hBB,
                    8'h00, smf_pkg::STATUS_META, 8'h00, 8'h00, 8'h00,
                    smf_pkg::STATUS_SYSEX, 8'h00,
                    8'h00, smf_pkg::STATUS_SYSEX_ESC, 8'h02, 8'h11,
                    smf_pkg::STATUS_SYSEX_ESC,
                    8'h00, smf_pkg::STATUS_META, smf_pkg::META_END_OF_TRACK, 8'h00}), 22);
      close_chunk(32'hFFFF_FFFF);
      // empty body
      close_chunk(32'd0);
      // length used up inside the first event
      add_seq(256'({8'h00, 8'h90, 8'h3C, 8'h40}), 4);
      close_chunk(32'd2);
      // end of track with a payload, exact length
      add_seq(256'({8'h00, smf_pkg::STATUS_META, smf_pkg::META_END_OF_TRACK, 8'h02,
                    8'hAB, 8'hCD}), 6);
      close_chunk(32'd6);
      // sysex ends the chunk by length
      add_seq(256'({8'h00, smf_pkg::STATUS_SYSEX, 8'h01, 8'h7E}), 4);
      close_chunk(32'd4);

      while (track_stream.size() < 2000) begin
         if ($urandom_range(0, 19) == 0) begin
            close_chunk(32'd0);
         end else begin
            n_events = $urandom_range(1, 10);
            mode = $urandom_range(0, 9);
            last_start = 0;
            for (i = 0; i < n_events; i++) begin
               last_start = chunk_body.size();
               add_event(mode >= 7 && i == n_events - 1);
            end
            if (mode <= 4 || mode == 7) begin
               body_len = chunk_body.size();
            end else if (mode <= 6) begin
               // runs out somewhere inside the final event
               body_len = $urandom_range(last_start + 1, chunk_body.size());
            end else if (mode == 8) begin
               body_len = chunk_body.size() + $urandom_range(1, 1000);
            end else begin
               body_len = $urandom;
               if (body_len < chunk_body.size()) body_len = chunk_body.size();
            end
            close_chunk(body_len);
         end
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (track_stream[k]) begin
         if ($urandom_range(0, 31) == 0) no_idle = !no_idle;
         gap = no_idle ? 0 : $urandom_range(0, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_track_byte <= track_stream[k];
         do @(posedge clock); while (!req_ready);
      end
      req_valid <= 1'b0;

      do @(negedge clock); while (pending != 0);
      repeat (20) @(posedge clock);
      if (failures == 0 && pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

FILE: sim.f
design/smf_pkg.sv
design/smf_parse_core.sv
design/smf_result_fifo.sv
design/smf_track_event_parser.sv
tb/smf_result_checker.sv
tb/tb.sv
